// ----- rtl/sgw_pkg.sv -----
package sgw_pkg;

  // Pattern geometry
  localparam int MAX_STEPS  = 256;
  localparam int LANE_COUNT = 8;
  localparam int STEP_TICKS = 24;

  // Physical lane slots on the input item
  localparam int LANES  = 8;
  localparam int VEL_W  = 8;
  localparam int NOTE_W = 7;
  localparam int GATE_W = 5;

  // Step counter holds 0..MAX_STEPS, tick holds up to MAX_STEPS*STEP_TICKS-1
  localparam int STEP_W  = $clog2(MAX_STEPS + 1);
  localparam int TICK_W  = (MAX_STEPS * STEP_TICKS > 1) ? $clog2(MAX_STEPS * STEP_TICKS) : 1;
  localparam int GCLP_W  = $clog2(STEP_TICKS);
  localparam int LAST_W  = 14;
  localparam int CMP_W   = (TICK_W > LAST_W) ? TICK_W : LAST_W;

  localparam logic [LAST_W-1:0] DELTA_MAX = 14'h3FFF;

  // Event codes
  localparam logic [7:0] ST_NOTE_ON  = 8'h99;
  localparam logic [7:0] ST_NOTE_OFF = 8'h89;
  localparam logic [7:0] ST_META     = 8'hFF;
  localparam logic [6:0] META_EOT    = 7'h2F;
  localparam logic [6:0] VEL_MAX     = 7'h7F;

  // Register map (index = paddr[4:3])
  localparam int          ADDR_W    = 5;
  localparam logic [1:0]  REG_MUTE  = 2'd0;
  localparam logic [1:0]  REG_NOTE  = 2'd1;
  localparam logic [1:0]  REG_GATE  = 2'd2;
  localparam logic [GATE_W-1:0] GATE_RESET = 5'd19;

  // What one lane reports for the current step
  typedef struct packed {
    logic              active;
    logic [NOTE_W-1:0] vel;
    logic [NOTE_W-1:0] note;
  } lane_t;

endpackage

// ----- rtl/sgw_lane.sv -----
module sgw_lane (
  input  logic [sgw_pkg::VEL_W-1:0]  velocity,
  input  logic                       mute,
  input  logic                       lane_en,
  input  logic [sgw_pkg::NOTE_W-1:0] note,
  output sgw_pkg::lane_t             res
);
  import sgw_pkg::*;

  // Qualify the lane and clamp its velocity
  always_comb begin
    res.active = lane_en & ~mute & (|velocity);
    res.vel    = velocity[VEL_W-1] ? VEL_MAX : velocity[NOTE_W-1:0];
    res.note   = note;
  end

endmodule

// ----- rtl/sgw_merge.sv -----
module sgw_merge (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       final_step,
  input  sgw_pkg::lane_t             lane_res [sgw_pkg::LANES],
  input  logic [sgw_pkg::GATE_W-1:0] gate_ticks,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [15:0]                out_delta_code,
  output logic [1:0]                 out_delta_length,
  output logic [7:0]                 out_status_byte,
  output logic [6:0]                 out_data_first,
  output logic [6:0]                 out_data_second,
  output logic                       out_last_of_run
);
  import sgw_pkg::*;

  // Held step
  logic [LANES-1:0]  on_rem_r, on_rem_nxt;
  logic [LANES-1:0]  off_rem_r, off_rem_nxt;
  logic              eot_r, eot_nxt;
  logic [TICK_W-1:0] on_tick_r, off_tick_r;
  logic [NOTE_W-1:0] vel_r  [LANES];
  logic [NOTE_W-1:0] note_r [LANES];
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [LAST_W-1:0] last_tick_r, last_tick_nxt;

  // Output register
  logic        out_valid_r;
  logic [15:0] delta_code_r;
  logic [1:0]  delta_len_r;
  logic [7:0]  status_r;
  logic [6:0]  data1_r, data2_r;
  logic        last_r;

  logic              busy, emit_go, capture, win, last_ev;
  logic              sel_on, sel_off, sel_eot;
  logic [LANES-1:0]  act_mask, cur_mask, pick, on_after, off_after;
  logic              eot_after;
  logic [NOTE_W-1:0] pick_vel, pick_note;
  logic [TICK_W-1:0] cap_on_tick, cap_off_tick, ev_tick;
  logic [GCLP_W-1:0] gate_eff;
  logic [CMP_W-1:0]  tick_ext, last_ext, delta_full;
  logic [LAST_W-1:0] delta;
  logic [15:0]       vlq_code;
  logic [1:0]        vlq_len;

  assign busy     = (|on_rem_r) | (|off_rem_r) | eot_r;
  assign emit_go  = busy & (~out_valid_r | out_ready);
  assign in_ready = ~busy | (emit_go & last_ev);
  assign capture  = in_valid & in_ready;
  assign win      = int'(step_r) < MAX_STEPS;

  // Gather lane flags and clamp the gate against the step length
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      act_mask[i] = lane_res[i].active;
    end
    if (gate_ticks == '0) begin
      gate_eff = GCLP_W'(1);
    end else if (int'(gate_ticks) >= STEP_TICKS) begin
      gate_eff = GCLP_W'(STEP_TICKS - 1);
    end else begin
      gate_eff = GCLP_W'(gate_ticks);
    end
    cap_on_tick  = TICK_W'(step_r) * TICK_W'(STEP_TICKS);
    cap_off_tick = cap_on_tick + TICK_W'(gate_eff);
  end

  // Pick the next event: ons first, then offs, then end of track
  always_comb begin
    sel_on   = |on_rem_r;
    sel_off  = ~sel_on & (|off_rem_r);
    sel_eot  = ~sel_on & ~sel_off & eot_r;
    cur_mask = sel_on ? on_rem_r : off_rem_r;
    pick     = cur_mask & (~cur_mask + LANES'(1));
    pick_vel  = '0;
    pick_note = '0;
    for (int i = 0; i < LANES; i++) begin
      pick_vel  = pick_vel  | (vel_r[i]  & {NOTE_W{pick[i]}});
      pick_note = pick_note | (note_r[i] & {NOTE_W{pick[i]}});
    end
    on_after  = sel_on  ? (on_rem_r & ~pick)  : on_rem_r;
    off_after = sel_off ? (off_rem_r & ~pick) : off_rem_r;
    eot_after = sel_eot ? 1'b0 : eot_r;
    last_ev   = (on_after == '0) & (off_after == '0) & ~eot_after;
  end

  // Delta from the last event tick, saturated, then VLQ coded
  always_comb begin
    ev_tick  = sel_on ? on_tick_r : off_tick_r;
    tick_ext = CMP_W'(ev_tick);
    last_ext = CMP_W'(last_tick_r);
    if (sel_eot || tick_ext <= last_ext) begin
      delta_full = '0;
    end else begin
      delta_full = tick_ext - last_ext;
    end
    delta = (delta_full > CMP_W'(DELTA_MAX)) ? DELTA_MAX : LAST_W'(delta_full);
    if (delta[LAST_W-1:7] == '0) begin
      vlq_code = {9'h000, delta[6:0]};
      vlq_len  = 2'd1;
    end else begin
      vlq_code = {1'b1, delta[13:7], 1'b0, delta[6:0]};
      vlq_len  = 2'd2;
    end
    if (sel_eot) begin
      last_tick_nxt = '0;
    end else if (tick_ext > CMP_W'(DELTA_MAX)) begin
      last_tick_nxt = DELTA_MAX;
    end else begin
      last_tick_nxt = LAST_W'(ev_tick);
    end
  end

  // Next held-step control
  always_comb begin
    on_rem_nxt  = on_rem_r;
    off_rem_nxt = off_rem_r;
    eot_nxt     = eot_r;
    step_nxt    = step_r;
    if (emit_go) begin
      on_rem_nxt  = on_after;
      off_rem_nxt = off_after;
      eot_nxt     = eot_after;
    end
    if (capture) begin
      on_rem_nxt  = win ? act_mask : '0;
      off_rem_nxt = win ? act_mask : '0;
      eot_nxt     = final_step;
      if (final_step) begin
        step_nxt = '0;
      end else if (win) begin
        step_nxt = step_r + STEP_W'(1);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_rem_r    <= '0;
      off_rem_r   <= '0;
      eot_r       <= 1'b0;
      step_r      <= '0;
      last_tick_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      on_rem_r  <= on_rem_nxt;
      off_rem_r <= off_rem_nxt;
      eot_r     <= eot_nxt;
      step_r    <= step_nxt;
      if (emit_go) begin
        last_tick_r <= last_tick_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture step payload
  always_ff @(posedge clk) begin
    if (capture) begin
      on_tick_r  <= cap_on_tick;
      off_tick_r <= cap_off_tick;
      for (int i = 0; i < LANES; i++) begin
        vel_r[i]  <= lane_res[i].vel;
        note_r[i] <= lane_res[i].note;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (emit_go) begin
      delta_code_r <= vlq_code;
      delta_len_r  <= vlq_len;
      last_r       <= last_ev;
      if (sel_eot) begin
        status_r <= ST_META;
        data1_r  <= META_EOT;
        data2_r  <= '0;
      end else begin
        status_r <= sel_on ? ST_NOTE_ON : ST_NOTE_OFF;
        data1_r  <= pick_note;
        data2_r  <= sel_on ? pick_vel : '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_delta_code   = delta_code_r;
  assign out_delta_length = delta_len_r;
  assign out_status_byte  = status_r;
  assign out_data_first   = data1_r;
  assign out_data_second  = data2_r;
  assign out_last_of_run  = last_r;

endmodule

// ----- rtl/step_grid_midi_event_writer_top.sv -----
// Channel   Handshake             Payload
// in_       in_valid/in_ready     in_velocity_lane0..7, in_final_step
// out_      out_valid/out_ready   out_delta_code, out_delta_length, out_status_byte,
//                                 out_data_first, out_data_second, out_last_of_run
// cfg       psel/penable/pwrite   paddr[4:3] = register index, pwdata/prdata 64 bits
//
// A step yields N results, N = 2 * active lanes + final flag (up to 17):
// the event sequencer emits one result per cycle into the output register while out_ready does not stall it.
// The next step is taken in the cycle its predecessor's last result is emitted.
// rst_n is synchronous; it clears the step counter, tick tracker and handshakes.
// A stalled out_ready holds the output register and stops the sequencer.
module step_grid_midi_event_writer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_velocity_lane0,
  input  logic [7:0]  in_velocity_lane1,
  input  logic [7:0]  in_velocity_lane2,
  input  logic [7:0]  in_velocity_lane3,
  input  logic [7:0]  in_velocity_lane4,
  input  logic [7:0]  in_velocity_lane5,
  input  logic [7:0]  in_velocity_lane6,
  input  logic [7:0]  in_velocity_lane7,
  input  logic        in_final_step,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_delta_code,
  output logic [1:0]  out_delta_length,
  output logic [7:0]  out_status_byte,
  output logic [6:0]  out_data_first,
  output logic [6:0]  out_data_second,
  output logic        out_last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [sgw_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import sgw_pkg::*;

  logic [LANES-1:0]        mute_r;
  logic [LANES*NOTE_W-1:0] note_tbl_r;
  logic [GATE_W-1:0]       gate_r;
  logic [1:0]              reg_idx;
  logic [VEL_W-1:0]        vel_in [LANES];
  lane_t                   lane_res [LANES];

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mute_r     <= '0;
      note_tbl_r <= '0;
      gate_r     <= GATE_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_MUTE: mute_r     <= pwdata[LANES-1:0];
        REG_NOTE: note_tbl_r <= pwdata[LANES*NOTE_W-1:0];
        REG_GATE: gate_r     <= pwdata[GATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx)
      REG_MUTE: prdata = 64'(mute_r);
      REG_NOTE: prdata = 64'(note_tbl_r);
      REG_GATE: prdata = 64'(gate_r);
      default:  prdata = '0;
    endcase
  end

  assign vel_in[0] = in_velocity_lane0;
  assign vel_in[1] = in_velocity_lane1;
  assign vel_in[2] = in_velocity_lane2;
  assign vel_in[3] = in_velocity_lane3;
  assign vel_in[4] = in_velocity_lane4;
  assign vel_in[5] = in_velocity_lane5;
  assign vel_in[6] = in_velocity_lane6;
  assign vel_in[7] = in_velocity_lane7;

  // One lane core per velocity slot
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    sgw_lane u_lane (
      .velocity (vel_in[i]),
      .mute     (mute_r[i]),
      .lane_en  (1'(i < LANE_COUNT)),
      .note     (note_tbl_r[i*NOTE_W +: NOTE_W]),
      .res      (lane_res[i])
    );
  end

  sgw_merge u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .final_step       (in_final_step),
    .lane_res         (lane_res),
    .gate_ticks       (gate_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_delta_code   (out_delta_code),
    .out_delta_length (out_delta_length),
    .out_status_byte  (out_status_byte),
    .out_data_first   (out_data_first),
    .out_data_second  (out_data_second),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

// ----- rtl/sgw_checker.sv -----
module sgw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_delta_code,
  input logic [1:0]  out_delta_length,
  input logic [7:0]  out_status_byte,
  input logic [6:0]  out_data_second,
  input logic        out_last_of_run
);
  import sgw_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // End of track always closes the step
  a_eot_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status_byte == ST_META |-> out_last_of_run)
    else $error("end of track not last of run");

  // Note-off carries zero velocity, note-on a nonzero one
  a_off_vel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status_byte == ST_NOTE_OFF |-> out_data_second == '0)
    else $error("note-off with velocity");

  a_on_vel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status_byte == ST_NOTE_ON |-> out_data_second != '0)
    else $error("note-on with zero velocity");

  // Single-byte VLQ leaves the upper bits clear
  a_vlq_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_delta_length == 2'd1 |-> out_delta_code[15:7] == '0)
    else $error("short VLQ with high bits set");

endmodule

bind step_grid_midi_event_writer_top sgw_checker u_sgw_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_delta_code   (out_delta_code),
  .out_delta_length (out_delta_length),
  .out_status_byte  (out_status_byte),
  .out_data_second  (out_data_second),
  .out_last_of_run  (out_last_of_run)
);
